// ===== src/tsf_pkg.sv =====
package tsf_pkg;

   // fixed-point format and field widths
   localparam int FRAC_BITS  = 28;
   localparam int MAX_TERMS  = 512;
   localparam int ACT_W      = 3;
   localparam int OPND_W     = 32;
   localparam int VAL_W      = 48;
   localparam int TERM_W     = 9;
   localparam int K_W        = 10;
   localparam int OPER_W     = 49;
   localparam int MAG_W      = 48;
   localparam int CHUNK_W    = 16;
   localparam int PROD_W     = 96;
   localparam int RND_W      = PROD_W + 1;
   localparam int Q_W        = RND_W - FRAC_BITS;
   localparam int TMP_W      = 60;
   localparam int WIDE_W     = 62;
   localparam int DIV_W      = 20;
   localparam int NUM_W      = 60;
   localparam int COEF_W     = 29;
   localparam int RADIX_BITS = 4;
   localparam int MUL_STEPS  = MAG_W / CHUNK_W;
   localparam int DIV_STEPS  = NUM_W / RADIX_BITS;
   localparam int STEP_W     = 4;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_TERM_COUNT = 1'b0;

   // term count limits
   localparam logic [TERM_W-1:0] TERM_RESET = 9'd510;
   localparam logic [TERM_W-1:0] TERM_MIN   = 9'd2;

   // function codes
   localparam logic [ACT_W-1:0] ACT_EXP  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SIN  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_COS  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_ASIN = 3'd3;
   localparam logic [ACT_W-1:0] ACT_LN   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_ACOS = 3'd5;

   // numeric constants
   localparam logic signed [VAL_W-1:0] ONE_Q     = 48'sd268435456;
   localparam logic signed [VAL_W-1:0] PI_HALF_Q = 48'sd421657428;
   localparam logic signed [VAL_W-1:0] VAL_MAX   = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN   = 48'sh8000_0000_0000;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ISSUE = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_MPOST = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_DPOST = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // micro-step of one Horner iteration
   typedef enum logic [8:0] {
      PH_X2  = 9'b000000001,
      PH_D1  = 9'b000000010,
      PH_D2  = 9'b000000100,
      PH_C   = 9'b000001000,
      PH_A   = 9'b000010000,
      PH_K   = 9'b000100000,
      PH_B   = 9'b001000000,
      PH_E   = 9'b010000000,
      PH_FIN = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    clip;
   } clip_type;

   // magnitude of a signed operand
   function automatic logic [MAG_W-1:0] mag(input logic signed [OPER_W-1:0] v);
      logic signed [OPER_W-1:0] n;
      n = -v;
      return v[OPER_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

   // clip to the 48-bit result range
   function automatic clip_type clip48(input logic signed [WIDE_W-1:0] v);
      clip_type r;
      if (v > WIDE_W'(VAL_MAX)) begin
         r.value = VAL_MAX;
         r.clip  = 1'b1;
      end else if (v < WIDE_W'(VAL_MIN)) begin
         r.value = VAL_MIN;
         r.clip  = 1'b1;
      end else begin
         r.value = v[VAL_W-1:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== src/tsf_req_if.sv =====
interface tsf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [tsf_pkg::ACT_W-1:0]            action;
   logic signed [tsf_pkg::OPND_W-1:0]    operand;

   modport source (output valid, output action, output operand, input ready);
   modport sink (input valid, input action, input operand, output ready);
endinterface

// ===== src/tsf_rsp_if.sv =====
interface tsf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tsf_pkg::VAL_W-1:0]    value;
   logic                                saturated;

   modport source (output valid, output value, output saturated, input ready);
   modport sink (input valid, input value, input saturated, output ready);
endinterface

// ===== src/taylor_series_function_unit.sv =====
// Each item runs S Horner steps: term_count for sin, cos and ln(1+x), one fewer for exp,
// arcsin and arccos.
// Every step runs through one shared 48x16 multiplier and one radix-16 divider;
// one item is in work at a time.
// The next item is taken once the previous one has moved to the output register.
// Synchronous active-high reset clears control state and sets term_count to 510.
module taylor_series_function_unit (
   input  logic                               clock,
   input  logic                               reset,
   tsf_req_if.sink                            req_chan,
   tsf_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tsf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tsf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tsf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   // control registers
   tsf_pkg::state_type                  state_ff, state_in;
   tsf_pkg::phase_type                  phase_ff, phase_in;
   logic [tsf_pkg::TERM_W-1:0]          term_count_ff, term_count_in;
   logic [tsf_pkg::STEP_W-1:0]          step_ff, step_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [tsf_pkg::ACT_W-1:0]           act_ff, act_in;
   logic signed [tsf_pkg::OPND_W-1:0]   x_ff, x_in;
   logic signed [tsf_pkg::VAL_W-1:0]    x2_ff, x2_in;
   logic signed [tsf_pkg::VAL_W-1:0]    acc_ff, acc_in;
   logic signed [tsf_pkg::TMP_W-1:0]    t_ff, t_in;
   logic [tsf_pkg::COEF_W-1:0]          c_ff, c_in;
   logic [tsf_pkg::K_W-1:0]             k_ff, k_in;
   logic [tsf_pkg::DIV_W-1:0]           d_ff, d_in;
   logic                                sat_ff, sat_in;
   logic signed [tsf_pkg::VAL_W-1:0]    res_ff, res_in;
   logic [tsf_pkg::MAG_W-1:0]           mul_a_ff, mul_a_in;
   logic [tsf_pkg::MAG_W-1:0]           mul_b_ff, mul_b_in;
   logic                                mul_neg_ff, mul_neg_in;
   logic [tsf_pkg::PROD_W-1:0]          prod_ff, prod_in;
   logic [tsf_pkg::NUM_W-1:0]           div_num_ff, div_num_in;
   logic [tsf_pkg::DIV_W-1:0]           div_rem_ff, div_rem_in;
   logic [tsf_pkg::DIV_W-1:0]           div_d_ff, div_d_in;
   logic                                div_neg_ff, div_neg_in;
   logic signed [tsf_pkg::VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                                rsp_sat_ff, rsp_sat_in;

   // combinational helpers
   logic                                csr_write;
   logic [tsf_pkg::TERM_W-1:0]          tc;
   logic [tsf_pkg::K_W-1:0]             k_start;
   logic [tsf_pkg::K_W+1:0]             k2p1, k2p2, k2p3;
   logic signed [tsf_pkg::OPER_W-1:0]   op_a, op_b;
   logic [tsf_pkg::RND_W-1:0]           rnd;
   logic [tsf_pkg::Q_W-1:0]             q_full, q_limit;
   logic                                mul_over;
   logic [tsf_pkg::MAG_W-1:0]           q_mag;
   logic signed [tsf_pkg::VAL_W-1:0]    rnd_val;
   logic signed [tsf_pkg::TMP_W-1:0]    raw_val;
   logic [tsf_pkg::NUM_W-1:0]           dv_num;
   logic [tsf_pkg::DIV_W:0]             dv_try;
   logic [tsf_pkg::DIV_W-1:0]           dv_rem;
   logic signed [tsf_pkg::WIDE_W-1:0]   quo_s;
   logic [tsf_pkg::DIV_W-1:0]           dsel;
   logic [tsf_pkg::TMP_W-1:0]           t_mag;
   logic signed [tsf_pkg::WIDE_W-1:0]   upd_wide;
   tsf_pkg::clip_type                   upd_clip, fin_clip;
   logic                                last_step;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[tsf_pkg::CSR_ADDR_W-1] == tsf_pkg::CSR_IDX_TERM_COUNT) ?
                       tsf_pkg::CSR_DATA_W'(term_count_ff) : '0;

   // channel ports
   assign req_chan.ready     = (state_ff == tsf_pkg::ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value     = rsp_value_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

   // clamped term count and first loop index
   always_comb begin
      tc = (term_count_ff < tsf_pkg::TERM_MIN) ? tsf_pkg::TERM_MIN : term_count_ff;
      case (req_chan.action) inside
         tsf_pkg::ACT_ASIN, tsf_pkg::ACT_ACOS: k_start = tsf_pkg::K_W'(tc) - 10'd2;
         tsf_pkg::ACT_LN:                       k_start = tsf_pkg::K_W'(tc);
         default:                               k_start = tsf_pkg::K_W'(tc) - 10'd1;
      endcase
   end

   // multiplier operand select
   always_comb begin
      k2p1 = {1'b0, k_ff, 1'b1};
      k2p2 = {1'b0, k_ff, 1'b0} + 12'd2;
      k2p3 = {1'b0, k_ff, 1'b0} + 12'd3;
      unique case (phase_ff)
         tsf_pkg::PH_X2: begin
            op_a = tsf_pkg::OPER_W'(x_ff);
            op_b = tsf_pkg::OPER_W'(x_ff);
         end
         tsf_pkg::PH_D1: begin
            if (act_ff == tsf_pkg::ACT_SIN) begin
               op_a = tsf_pkg::OPER_W'(k2p2);
               op_b = tsf_pkg::OPER_W'(k2p3);
            end else if (act_ff == tsf_pkg::ACT_COS) begin
               op_a = tsf_pkg::OPER_W'(k2p2);
               op_b = tsf_pkg::OPER_W'(k2p1);
            end else begin
               op_a = tsf_pkg::OPER_W'(k2p1);
               op_b = tsf_pkg::OPER_W'(k2p1);
            end
         end
         tsf_pkg::PH_D2: begin
            op_a = tsf_pkg::OPER_W'({1'b0, k_ff} + 11'd1);
            op_b = tsf_pkg::OPER_W'(k2p3);
         end
         tsf_pkg::PH_A: begin
            op_a = (act_ff == tsf_pkg::ACT_EXP || act_ff == tsf_pkg::ACT_LN) ?
                   tsf_pkg::OPER_W'(x_ff) : tsf_pkg::OPER_W'(x2_ff);
            op_b = tsf_pkg::OPER_W'(acc_ff);
         end
         tsf_pkg::PH_K: begin
            op_a = t_ff[tsf_pkg::OPER_W-1:0];
            op_b = tsf_pkg::OPER_W'(k_ff);
         end
         tsf_pkg::PH_E: begin
            op_a = t_ff[tsf_pkg::OPER_W-1:0];
            op_b = tsf_pkg::OPER_W'(c_ff);
         end
         default: begin
            op_a = tsf_pkg::OPER_W'(x_ff);
            op_b = tsf_pkg::OPER_W'(acc_ff);
         end
      endcase
   end

   // product rounding and clipping
   always_comb begin
      rnd      = {1'b0, prod_ff} + (tsf_pkg::RND_W'(1) << (tsf_pkg::FRAC_BITS - 1));
      q_full   = rnd[tsf_pkg::RND_W-1:tsf_pkg::FRAC_BITS];
      q_limit  = mul_neg_ff ? (tsf_pkg::Q_W'(1) << (tsf_pkg::VAL_W - 1)) :
                 ((tsf_pkg::Q_W'(1) << (tsf_pkg::VAL_W - 1)) - tsf_pkg::Q_W'(1));
      mul_over = q_full > q_limit;
      q_mag    = mul_over ? q_limit[tsf_pkg::MAG_W-1:0] : q_full[tsf_pkg::MAG_W-1:0];
      rnd_val  = mul_neg_ff ? -$signed(q_mag) : $signed(q_mag);
      raw_val  = mul_neg_ff ? -$signed(prod_ff[tsf_pkg::TMP_W-1:0]) :
                 $signed(prod_ff[tsf_pkg::TMP_W-1:0]);
   end

   // four restoring division steps per cycle
   always_comb begin
      dv_num = div_num_ff;
      dv_rem = div_rem_ff;
      dv_try = '0;
      for (int i = 0; i < tsf_pkg::RADIX_BITS; i++) begin
         dv_try = {dv_rem, dv_num[tsf_pkg::NUM_W-1]};
         dv_num = {dv_num[tsf_pkg::NUM_W-2:0], 1'b0};
         if (dv_try >= {1'b0, div_d_ff}) begin
            dv_try    = dv_try - {1'b0, div_d_ff};
            dv_num[0] = 1'b1;
         end
         dv_rem = dv_try[tsf_pkg::DIV_W-1:0];
      end
   end

   // divisor select, dividend magnitude, quotient sign
   always_comb begin
      if (act_ff == tsf_pkg::ACT_EXP) begin
         dsel = tsf_pkg::DIV_W'(k_ff);
      end else if (act_ff == tsf_pkg::ACT_LN) begin
         dsel = tsf_pkg::DIV_W'(k_ff) + 20'd1;
      end else begin
         dsel = d_ff;
      end
      t_mag = t_ff[tsf_pkg::TMP_W-1] ? tsf_pkg::TMP_W'(-t_ff) : tsf_pkg::TMP_W'(t_ff);
      quo_s = div_neg_ff ? -$signed({2'b00, div_num_ff}) : $signed({2'b00, div_num_ff});
   end

   // accumulator update at the end of a Horner step
   always_comb begin
      if (phase_ff == tsf_pkg::PH_E) begin
         upd_wide = tsf_pkg::WIDE_W'(tsf_pkg::ONE_Q) + tsf_pkg::WIDE_W'(rnd_val);
      end else if (act_ff == tsf_pkg::ACT_EXP) begin
         upd_wide = tsf_pkg::WIDE_W'(tsf_pkg::ONE_Q) + quo_s;
      end else begin
         upd_wide = tsf_pkg::WIDE_W'(tsf_pkg::ONE_Q) - quo_s;
      end
      upd_clip  = tsf_pkg::clip48(upd_wide);
      fin_clip  = tsf_pkg::clip48(tsf_pkg::WIDE_W'(tsf_pkg::PI_HALF_Q) -
                                  tsf_pkg::WIDE_W'(rnd_val));
      last_step = (act_ff == tsf_pkg::ACT_EXP || act_ff == tsf_pkg::ACT_LN) ?
                  (k_ff == 10'd1) : (k_ff == 10'd0);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      term_count_in = term_count_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      act_in        = act_ff;
      x_in          = x_ff;
      x2_in         = x2_ff;
      acc_in        = acc_ff;
      t_in          = t_ff;
      c_in          = c_ff;
      k_in          = k_ff;
      d_in          = d_ff;
      sat_in        = sat_ff;
      res_in        = res_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      mul_neg_in    = mul_neg_ff;
      prod_in       = prod_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_d_in      = div_d_ff;
      div_neg_in    = div_neg_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_sat_in    = rsp_sat_ff;

      if (csr_write &&
          csr_paddr[tsf_pkg::CSR_ADDR_W-1] == tsf_pkg::CSR_IDX_TERM_COUNT) begin
         term_count_in = csr_pwdata[tsf_pkg::TERM_W-1:0];
      end

      // result taken downstream
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         tsf_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               act_in   = req_chan.action;
               x_in     = req_chan.operand;
               acc_in   = tsf_pkg::ONE_Q;
               sat_in   = 1'b0;
               k_in     = k_start;
               phase_in = tsf_pkg::PH_X2;
               if (req_chan.action > tsf_pkg::ACT_ACOS) begin
                  res_in   = '0;
                  state_in = tsf_pkg::ST_DONE;
               end else begin
                  state_in = tsf_pkg::ST_ISSUE;
               end
            end
         end
         tsf_pkg::ST_ISSUE: begin
            step_in = '0;
            if (phase_ff == tsf_pkg::PH_C) begin
               div_d_in   = d_ff;
               div_neg_in = 1'b0;
               div_num_in = (tsf_pkg::NUM_W'(t_ff[tsf_pkg::DIV_W-1:0]) << tsf_pkg::FRAC_BITS) +
                            tsf_pkg::NUM_W'(d_ff >> 1);
               div_rem_in = '0;
               state_in   = tsf_pkg::ST_DIV;
            end else if (phase_ff == tsf_pkg::PH_B) begin
               div_d_in   = dsel;
               div_neg_in = t_ff[tsf_pkg::TMP_W-1];
               div_num_in = t_mag + tsf_pkg::NUM_W'(dsel >> 1);
               div_rem_in = '0;
               state_in   = tsf_pkg::ST_DIV;
            end else begin
               mul_a_in   = tsf_pkg::mag(op_a);
               mul_b_in   = tsf_pkg::mag(op_b);
               mul_neg_in = op_a[tsf_pkg::OPER_W-1] ^ op_b[tsf_pkg::OPER_W-1];
               prod_in    = '0;
               state_in   = tsf_pkg::ST_MUL;
            end
         end
         tsf_pkg::ST_MUL: begin
            // most significant chunk first, shift-accumulate
            prod_in  = {prod_ff[tsf_pkg::PROD_W-tsf_pkg::CHUNK_W-1:0], {tsf_pkg::CHUNK_W{1'b0}}} +
                       tsf_pkg::PROD_W'(mul_a_ff *
                                        mul_b_ff[tsf_pkg::MAG_W-1 -: tsf_pkg::CHUNK_W]);
            mul_b_in = mul_b_ff << tsf_pkg::CHUNK_W;
            step_in  = step_ff + 4'd1;
            if (step_ff == tsf_pkg::STEP_W'(tsf_pkg::MUL_STEPS - 1)) begin
               state_in = tsf_pkg::ST_MPOST;
            end
         end
         tsf_pkg::ST_MPOST: begin
            state_in = tsf_pkg::ST_ISSUE;
            unique case (phase_ff)
               tsf_pkg::PH_X2: begin
                  x2_in    = rnd_val;
                  phase_in = (act_ff == tsf_pkg::ACT_EXP || act_ff == tsf_pkg::ACT_LN) ?
                             tsf_pkg::PH_A : tsf_pkg::PH_D1;
               end
               tsf_pkg::PH_D1: begin
                  if (act_ff == tsf_pkg::ACT_SIN || act_ff == tsf_pkg::ACT_COS) begin
                     d_in     = raw_val[tsf_pkg::DIV_W-1:0];
                     phase_in = tsf_pkg::PH_A;
                  end else begin
                     t_in     = raw_val;
                     phase_in = tsf_pkg::PH_D2;
                  end
               end
               tsf_pkg::PH_D2: begin
                  d_in     = {raw_val[tsf_pkg::DIV_W-2:0], 1'b0};
                  phase_in = tsf_pkg::PH_C;
               end
               tsf_pkg::PH_A: begin
                  t_in   = tsf_pkg::TMP_W'(rnd_val);
                  sat_in = sat_ff | mul_over;
                  if (act_ff == tsf_pkg::ACT_LN) begin
                     phase_in = tsf_pkg::PH_K;
                  end else if (act_ff == tsf_pkg::ACT_ASIN || act_ff == tsf_pkg::ACT_ACOS) begin
                     phase_in = tsf_pkg::PH_E;
                  end else begin
                     phase_in = tsf_pkg::PH_B;
                  end
               end
               tsf_pkg::PH_K: begin
                  t_in     = raw_val;
                  phase_in = tsf_pkg::PH_B;
               end
               tsf_pkg::PH_E: begin
                  acc_in = upd_clip.value;
                  sat_in = sat_ff | mul_over | upd_clip.clip;
                  if (last_step) begin
                     phase_in = tsf_pkg::PH_FIN;
                  end else begin
                     k_in     = k_ff - 10'd1;
                     phase_in = tsf_pkg::PH_D1;
                  end
               end
               default: begin
                  // final multiply by x, arccos folds in pi/2
                  state_in = tsf_pkg::ST_DONE;
                  if (act_ff == tsf_pkg::ACT_ACOS) begin
                     res_in = fin_clip.value;
                     sat_in = sat_ff | mul_over | fin_clip.clip;
                  end else begin
                     res_in = rnd_val;
                     sat_in = sat_ff | mul_over;
                  end
               end
            endcase
         end
         tsf_pkg::ST_DIV: begin
            div_num_in = dv_num;
            div_rem_in = dv_rem;
            step_in    = step_ff + 4'd1;
            if (step_ff == tsf_pkg::STEP_W'(tsf_pkg::DIV_STEPS - 1)) begin
               state_in = tsf_pkg::ST_DPOST;
            end
         end
         tsf_pkg::ST_DPOST: begin
            state_in = tsf_pkg::ST_ISSUE;
            if (phase_ff == tsf_pkg::PH_C) begin
               c_in     = div_num_ff[tsf_pkg::COEF_W-1:0];
               phase_in = tsf_pkg::PH_A;
            end else begin
               acc_in = upd_clip.value;
               sat_in = sat_ff | upd_clip.clip;
               if (last_step) begin
                  if (act_ff == tsf_pkg::ACT_EXP || act_ff == tsf_pkg::ACT_COS) begin
                     res_in   = upd_clip.value;
                     state_in = tsf_pkg::ST_DONE;
                  end else begin
                     phase_in = tsf_pkg::PH_FIN;
                  end
               end else begin
                  k_in     = k_ff - 10'd1;
                  phase_in = (act_ff == tsf_pkg::ACT_EXP || act_ff == tsf_pkg::ACT_LN) ?
                             tsf_pkg::PH_A : tsf_pkg::PH_D1;
               end
            end
         end
         tsf_pkg::ST_DONE: begin
            // move the item to the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_sat_in   = sat_ff;
               state_in     = tsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsf_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tsf_pkg::ST_IDLE;
         phase_ff      <= tsf_pkg::PH_X2;
         term_count_ff <= tsf_pkg::TERM_RESET;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         term_count_ff <= term_count_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      x_ff         <= x_in;
      x2_ff        <= x2_in;
      acc_ff       <= acc_in;
      t_ff         <= t_in;
      c_ff         <= c_in;
      k_ff         <= k_in;
      d_ff         <= d_in;
      sat_ff       <= sat_in;
      res_ff       <= res_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      mul_neg_ff   <= mul_neg_in;
      prod_ff      <= prod_in;
      div_num_ff   <= div_num_in;
      div_rem_ff   <= div_rem_in;
      div_d_ff     <= div_d_in;
      div_neg_ff   <= div_neg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

endmodule

// ===== tb/taylor_series_function_unit_tb.sv =====
`timescale 1ns / 100ps

module taylor_series_function_unit_tb;

   typedef struct {
      logic [tsf_pkg::ACT_W-1:0]         action;
      logic signed [tsf_pkg::OPND_W-1:0] operand;
   } func_item_type;

   typedef struct {
      logic signed [tsf_pkg::VAL_W-1:0] value;
      logic                             saturated;
   } func_result_type;

   localparam longint Q_ONE   = longint'(1) << tsf_pkg::FRAC_BITS;
   localparam longint OUT_MAX = (longint'(1) << 47) - 1;
   localparam longint OUT_MIN = -(longint'(1) << 47);
   localparam logic [63:0] PI_HALF_Q61 = 64'h3243F6A8885A308D;
   localparam logic [tsf_pkg::ACT_W-1:0] ACT_LAST = {tsf_pkg::ACT_W{1'b1}};

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [tsf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [tsf_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [tsf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   tsf_req_if req_bus ();
   tsf_rsp_if rsp_bus ();

   taylor_series_function_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   func_item_type   pending_items[$];
   func_result_type expected_results[$];
   logic [tsf_pkg::TERM_W-1:0] terms_cfg;
   bit  clip_hit;
   bit  quiet;
   bit  hold_request;
   bit  req_taken;
   int  hold_count;
   int  errors;
   int  items_sent;
   int  items_queued;
   int  results_seen;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- series predictor ----------------
   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint clip_out(longint v);
      if (v > OUT_MAX) begin
         clip_hit = 1'b1;
         return OUT_MAX;
      end
      if (v < OUT_MIN) begin
         clip_hit = 1'b1;
         return OUT_MIN;
      end
      return v;
   endfunction

   // rounded fixed-point product, clipped to the output range
   function automatic longint mul_round(longint a, longint b);
      logic neg;
      logic [127:0] p;
      logic [127:0] q;
      logic [127:0] lim;
      neg = (a < 0) != (b < 0);
      p = 128'(magnitude(a)) * 128'(magnitude(b));
      q = (p + (128'd1 << (tsf_pkg::FRAC_BITS - 1))) >> tsf_pkg::FRAC_BITS;
      lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
      if (q > lim) begin
         q = lim;
         clip_hit = 1'b1;
      end
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint div_round(longint a, longint d);
      logic [63:0] q;
      q = (magnitude(a) + 64'(d) / 2) / 64'(d);
      return a < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic func_result_type compute_function(func_item_type it,
                                                        logic [tsf_pkg::TERM_W-1:0] tc);
      func_result_type r;
      longint t, x, x2, acc, res, d, ph;
      logic [63:0] n, dd, c;
      t = tc;
      if (t < 2) t = 2;
      if (t > tsf_pkg::MAX_TERMS - 1) t = tsf_pkg::MAX_TERMS - 1;
      x = it.operand;
      x2 = mul_round(x, x);
      acc = Q_ONE;
      clip_hit = 1'b0;
      case (it.action) inside
         tsf_pkg::ACT_EXP: begin
            for (longint k = t - 1; k >= 1; k--)
               acc = clip_out(Q_ONE + div_round(mul_round(x, acc), k));
            res = acc;
         end
         tsf_pkg::ACT_SIN, tsf_pkg::ACT_COS: begin
            for (longint k = t - 1; k >= 0; k--) begin
               d = (2 * k + 2) * (it.action == tsf_pkg::ACT_SIN ? 2 * k + 3 : 2 * k + 1);
               acc = clip_out(Q_ONE - div_round(mul_round(x2, acc), d));
            end
            res = it.action == tsf_pkg::ACT_SIN ? mul_round(x, acc) : acc;
         end
         tsf_pkg::ACT_ASIN, tsf_pkg::ACT_ACOS: begin
            for (longint k = t - 2; k >= 0; k--) begin
               n = 64'((2 * k + 1) * (2 * k + 1));
               dd = 64'(2 * (k + 1) * (2 * k + 3));
               c = ((n << tsf_pkg::FRAC_BITS) + dd / 2) / dd;
               acc = clip_out(Q_ONE + mul_round(mul_round(x2, acc), longint'(c)));
            end
            res = mul_round(x, acc);
            if (it.action == tsf_pkg::ACT_ACOS) begin
               ph = longint'((PI_HALF_Q61 + (64'd1 << (60 - tsf_pkg::FRAC_BITS))) >>
                             (61 - tsf_pkg::FRAC_BITS));
               res = clip_out(ph - res);
            end
         end
         tsf_pkg::ACT_LN: begin
            for (longint k = t; k >= 1; k--)
               acc = clip_out(Q_ONE - div_round(mul_round(x, acc) * k, k + 1));
            res = mul_round(x, acc);
         end
         default: begin
            res = 0;
            clip_hit = 1'b0;
         end
      endcase
      r.value = res[tsf_pkg::VAL_W-1:0];
      r.saturated = clip_hit;
      return r;
   endfunction

   // ---------------- driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
            req_bus.valid   <= 1'b1;
            req_bus.action  <= pending_items[0].action;
            req_bus.operand <= pending_items[0].operand;
            void'(pending_items.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver ready, with a counted long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_count <= 0;
      end else if (hold_request && hold_count < 400) begin
         rsp_bus.ready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         if (hold_request) hold_request <= 1'b0;
         hold_count <= 0;
         rsp_bus.ready <= quiet || $urandom_range(99) >= 7;
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      func_item_type   it;
      func_result_type ex;
      req_taken <= req_bus.valid && req_bus.ready && !reset;
      if (!reset && req_bus.valid && req_bus.ready) begin
         it.action  = req_bus.action;
         it.operand = req_bus.operand;
         expected_results.push_back(compute_function(it, terms_cfg));
         items_sent++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("result with no expectation: value %0d", rsp_bus.value);
            errors++;
         end else begin
            ex = expected_results.pop_front();
            if (rsp_bus.value !== ex.value) begin
               $error("value: expected %0d actual %0d", ex.value, rsp_bus.value);
               errors++;
            end
            if (rsp_bus.saturated !== ex.saturated) begin
               $error("saturated: expected %0d actual %0d", ex.saturated, rsp_bus.saturated);
               errors++;
            end
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic add_item(logic [tsf_pkg::ACT_W-1:0] a, logic signed [tsf_pkg::OPND_W-1:0] op);
      func_item_type it;
      it.action = a;
      it.operand = op;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // every queued item has come back as a result
   task automatic wait_idle();
      wait (results_seen == items_queued);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_terms(logic [tsf_pkg::TERM_W-1:0] v);
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= tsf_pkg::CSR_ADDR_W'(4 * tsf_pkg::CSR_IDX_TERM_COUNT);
      csr_pwdata <= tsf_pkg::CSR_DATA_W'(v);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      terms_cfg = v;
   endtask

   task automatic add_random(int count);
      logic [tsf_pkg::ACT_W-1:0] a;
      logic signed [tsf_pkg::OPND_W-1:0] op;
      repeat (count) begin
         a = ($urandom_range(99) < 5) ?
             ACT_LAST - tsf_pkg::ACT_W'($urandom_range(1)) :
             tsf_pkg::ACT_W'($urandom_range(tsf_pkg::ACT_ACOS));
         case ($urandom_range(3))
            0: op = $urandom;
            1: op = $signed(32'($urandom_range(32'h2000_0000))) - 32'sh1000_0000;
            default: op = $signed(32'($urandom_range(32'h4000_0000))) - 32'sh2000_0000;
         endcase
         add_item(a, op);
      end
   endtask

   initial begin
      logic [tsf_pkg::TERM_W-1:0] settings[10];
      int counts[10];
      settings = '{2, 3, 5, 8, 12, 0, 1, 511, 20, 300};
      counts   = '{60, 60, 60, 70, 60, 30, 30, 3, 50, 3};
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = '0;
      req_bus.operand = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      terms_cfg = tsf_pkg::TERM_RESET;
      quiet = 1'b0;
      hold_request = 1'b0;
      req_taken = 1'b0;
      errors = 0;
      items_sent = 0;
      items_queued = 0;
      results_seen = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // full-length series after reset
      add_item(tsf_pkg::ACT_EXP, 32'sh1000_0000);
      add_item(tsf_pkg::ACT_SIN, 32'sh1000_0000);
      wait_idle();

      // directed: extremes, every function, divergence, unused codes
      write_terms(9'd4);
      for (int a = tsf_pkg::ACT_EXP; a <= tsf_pkg::ACT_ACOS; a++) begin
         add_item(tsf_pkg::ACT_W'(a), 32'sh0);
         add_item(tsf_pkg::ACT_W'(a), 32'sh7FFF_FFFF);
         add_item(tsf_pkg::ACT_W'(a), 32'sh8000_0000);
      end
      add_item(tsf_pkg::ACT_ASIN, 32'sh0800_0000);
      add_item(tsf_pkg::ACT_ACOS, -32'sh0800_0000);
      add_item(tsf_pkg::ACT_LN, 32'sh1000_0000);
      add_item(tsf_pkg::ACT_LN, -32'sh1000_0000);
      add_item(tsf_pkg::ACT_ACOS + 3'd1, 32'sh1234_5678);
      add_item(ACT_LAST, -32'sh1);
      wait_idle();

      // random phases across term counts
      for (int p = 0; p < 10; p++) begin
         write_terms(settings[p]);
         quiet = (p == 3);
         if (p == 1) hold_request = 1'b1;
         add_random(counts[p]);
         wait_idle();
      end
      quiet = 1'b0;
      repeat (200) @(posedge clock);

      $display("covered %0d items and %0d results over 12 term counts incl. clamped ones",
               items_sent, results_seen);
      $display("all six functions, unused codes, divergent and saturating arguments");
      if (errors == 0 && expected_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // overall limit
   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
